### rtl/core/csx_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the column opaque span extractor.
// No dependencies; every other file imports this package.
package csx_pkg;

  // Field widths
  localparam int PixelW  = 32;
  localparam int RowW    = 10;
  localparam int LenW    = 11;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 11;

  // Height limits and reset values
  localparam logic [LenW-1:0] MaxHeight       = 11'd1024;
  localparam logic [CfgW-1:0] HeightResetVal  = 11'd64;
  localparam logic            WideResetVal    = 1'b0;
  localparam logic            HolesResetVal   = 1'b1;

  // Result queue
  localparam int QueueDepth = 4;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_COLUMN_HEIGHT = 2'd0,
    REG_WIDE_PIXELS   = 2'd1,
    REG_HAS_HOLES     = 2'd2
  } cfg_reg_t;

  // One result word
  typedef struct packed {
    logic [RowW-1:0] top_row;
    logic [LenW-1:0] run_length;
    logic            column_end;
  } result_t;

  // Results produced by one pixel: count (0..2) and up to two words
  typedef struct packed {
    logic [1:0] n;
    result_t    slot0;
    result_t    slot1;
  } push_t;

endpackage

### rtl/core/csx_pixel_if.sv
`timescale 1ns / 1ps
// Pixel input channel: valid/ready handshake with one 32-bit pixel word.
// Depends on csx_pkg.
interface csx_pixel_if import csx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PixelW-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

### rtl/core/csx_span_if.sv
`timescale 1ns / 1ps
// Span result channel: valid/ready handshake with top row, length and end flag.
// Depends on csx_pkg.
interface csx_span_if import csx_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RowW-1:0] top_row;
  logic [LenW-1:0] run_length;
  logic            column_end;

  modport source (output valid, output top_row, output run_length, output column_end,
                  input ready);
  modport sink   (input valid, input top_row, input run_length, input column_end,
                  output ready);
endinterface

### rtl/core/csx_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on csx_pkg.
interface csx_cfg_if import csx_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/csx_span_tracker.sv
`timescale 1ns / 1ps
// Per-pixel run tracking: holds row/run state and forms up to two result words.
// Depends on csx_pkg.
module csx_span_tracker import csx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [PixelW-1:0] pixel,
  input  logic [LenW-1:0]   height,
  input  logic              wide_pixels,
  input  logic              has_holes,
  output push_t             push
);

  logic [RowW-1:0] row_index_r, row_index_nxt;
  logic            in_run_r, in_run_nxt;
  logic [RowW-1:0] run_start_r, run_start_nxt;
  logic [LenW-1:0] run_count_r, run_count_nxt;

  logic            clear;
  logic            last;
  logic            run_in_nxt;
  logic [RowW-1:0] start_upd;
  logic [LenW-1:0] count_upd;
  logic            span_v;
  logic            term_v;
  result_t         span_w;
  result_t         term_w;

  always_comb begin
    // classify the pixel
    clear = wide_pixels ? (pixel[31:24] == 8'd0) : (pixel[7:0] == 8'd0);
    last  = ({1'b0, row_index_r} >= (height - 11'd1));

    // advance run state
    run_in_nxt = in_run_r;
    start_upd  = run_start_r;
    count_upd  = run_count_r;
    span_v     = 1'b0;
    span_w     = '0;
    if (clear) begin
      if (in_run_r && has_holes) begin
        span_v = 1'b1;
        span_w = '{top_row: run_start_r, run_length: run_count_r, column_end: 1'b0};
      end
      run_in_nxt = 1'b0;
    end else if (!in_run_r) begin
      run_in_nxt = 1'b1;
      start_upd  = row_index_r;
      count_upd  = 11'd1;
    end else begin
      count_upd = run_count_r + 11'd1;
    end

    // close the column on its last row
    term_v = last;
    term_w = '{top_row: '0, run_length: '0, column_end: 1'b1};
    if (last) begin
      if (has_holes) begin
        if (run_in_nxt) begin
          span_v = 1'b1;
          span_w = '{top_row: start_upd, run_length: count_upd, column_end: 1'b0};
        end
      end else begin
        span_v = 1'b1;
        span_w = '{top_row: '0, run_length: height, column_end: 1'b0};
      end
    end

    // pack results
    push.n     = {1'b0, span_v} + {1'b0, term_v};
    push.slot0 = span_v ? span_w : term_w;
    push.slot1 = term_w;
    if (!accept) push.n = 2'd0;

    // next state
    if (last) begin
      row_index_nxt = '0;
      in_run_nxt    = 1'b0;
      run_start_nxt = '0;
      run_count_nxt = '0;
    end else begin
      row_index_nxt = row_index_r + 10'd1;
      in_run_nxt    = run_in_nxt;
      run_start_nxt = start_upd;
      run_count_nxt = count_upd;
    end
  end

  // hold state between pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_index_r <= '0;
      in_run_r    <= 1'b0;
      run_start_r <= '0;
      run_count_r <= '0;
    end else if (accept) begin
      row_index_r <= row_index_nxt;
      in_run_r    <= in_run_nxt;
      run_start_r <= run_start_nxt;
      run_count_r <= run_count_nxt;
    end
  end

endmodule

### rtl/core/csx_result_queue.sv
`timescale 1ns / 1ps
// Small result queue: takes up to two words per cycle, hands out one per cycle while out_res.ready is high.
// Depends on csx_pkg.
module csx_result_queue import csx_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room,
  csx_span_if.source out_res
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  result_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            pop;
  logic [PtrW-1:0] wr_ptr_p1;

  assign pop       = out_res.valid && out_res.ready;
  assign wr_ptr_p1 = wr_ptr_r + PtrW'(1);

  // room for a full pair of words
  assign room = (count_r <= CntW'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PtrW'(push.n);
    rd_ptr_nxt = pop ? rd_ptr_r + PtrW'(1) : rd_ptr_r;
    count_nxt  = count_r + CntW'(push.n) - CntW'(pop);
  end

  // store pushed words
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.slot0;
    if (push.n == 2'd2) mem_r[wr_ptr_p1] <= push.slot1;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign out_res.valid      = (count_r != '0);
  assign out_res.top_row    = mem_r[rd_ptr_r].top_row;
  assign out_res.run_length = mem_r[rd_ptr_r].run_length;
  assign out_res.column_end = mem_r[rd_ptr_r].column_end;

endmodule

### rtl/core/column_opaque_span_extractor_core.sv
`timescale 1ns / 1ps
// Column opaque span extractor, top level.
// A pixel's results are in the result queue from the cycle after it is taken.
// Throughput: one pixel per cycle while the queue has room. A column of height H yields at most
// (H+1)/2+1 words, so the single-word output port keeps up except on single-row columns, two words a pixel.
// Reset (rst_n, synchronous): clears row/run state, empties the queue, restores registers.
module column_opaque_span_extractor_core import csx_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  csx_pixel_if.sink  in_px,
  csx_span_if.source out_res,
  csx_cfg_if.sink    cfg_wr
);

  logic [CfgW-1:0] column_height_r;
  logic            wide_pixels_r;
  logic            has_holes_r;
  logic [LenW-1:0] height;
  logic            room;
  logic            accept;
  push_t           push;

  // configuration registers
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_height_r <= HeightResetVal;
      wide_pixels_r   <= WideResetVal;
      has_holes_r     <= HolesResetVal;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_COLUMN_HEIGHT: column_height_r <= cfg_wr.data;
        REG_WIDE_PIXELS:   wide_pixels_r   <= cfg_wr.data[0];
        REG_HAS_HOLES:     has_holes_r     <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  // clamp height into 1..MaxHeight
  always_comb begin
    if (column_height_r == '0)          height = 11'd1;
    else if (column_height_r > MaxHeight) height = MaxHeight;
    else                                height = column_height_r;
  end

  assign in_px.ready = room;
  assign accept      = in_px.valid && room;

  csx_span_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .pixel       (in_px.pixel),
    .height      (height),
    .wide_pixels (wide_pixels_r),
    .has_holes   (has_holes_r),
    .push        (push)
  );

  csx_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .out_res (out_res)
  );

endmodule

### verif/column_opaque_span_extractor_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for column_opaque_span_extractor_core: streams texture pixels,
// predicts the span words of every column and checks them in order against the block.
// Depends on csx_pkg and the csx_pixel_if, csx_span_if and csx_cfg_if interfaces.
module column_opaque_span_extractor_core_tb;
  import csx_pkg::*;

  localparam int ClkPeriod    = 4;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam int PartPixels   = 80;
  localparam int LongHold     = 300;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [CfgIdxW-1:0] RegUnused     = 2'd3;
  localparam logic [CfgW-1:0]    HeightOverMax = 11'd2047;

  logic clk;
  logic rst_n;

  csx_pixel_if px_ch ();
  csx_span_if  span_ch ();
  csx_cfg_if   cfg_ch ();

  column_opaque_span_extractor_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_px   (px_ch),
    .out_res (span_ch),
    .cfg_wr  (cfg_ch)
  );

  logic [PixelW-1:0] pixels_todo[$];
  result_t           spans_due[$];
  result_t           span_exp;
  int                n_errors;
  int                cycles = 0;
  int                tx_idle_pct;
  int                rx_idle_pct;
  int                rx_hold_left;
  bit                tx_hold;
  logic              px_fired;
  logic              cfg_fired;

  // Shadow registers and column tracking state
  logic [CfgW-1:0] cur_height;
  logic            cur_wide;
  logic            cur_holes;
  logic [RowW-1:0] row_at;
  logic            run_open;
  logic [RowW-1:0] run_top;
  logic [LenW-1:0] run_len;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  function automatic void add_span(logic [RowW-1:0] top, logic [LenW-1:0] len,
                                   logic col_end);
    result_t w;
    w.top_row    = top;
    w.run_length = len;
    w.column_end = col_end;
    spans_due.push_back(w);
  endfunction

  function automatic void clear_tracking();
    row_at   = '0;
    run_open = 1'b0;
    run_top  = '0;
    run_len  = '0;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    case (idx)
      REG_COLUMN_HEIGHT: cur_height = val;
      REG_WIDE_PIXELS:   cur_wide   = val[0];
      REG_HAS_HOLES:     cur_holes  = val[0];
      default: ;
    endcase
  endfunction

  // Advance the column state by one pixel and queue the span words it closes
  function automatic void track_pixel(logic [PixelW-1:0] px);
    logic [LenW-1:0] eff_h;
    logic            see_through;
    logic            last_row;
    eff_h = cur_height;
    if (eff_h == '0) eff_h = 11'd1;
    if (eff_h > MaxHeight) eff_h = MaxHeight;
    last_row    = ({1'b0, row_at} >= eff_h - 11'd1);
    see_through = cur_wide ? (px[31:24] == 8'h00) : (px[7:0] == 8'h00);

    if (see_through) begin
      if (run_open) begin
        if (cur_holes) add_span(run_top, run_len, 1'b0);
        run_open = 1'b0;
      end
    end else if (!run_open) begin
      run_open = 1'b1;
      run_top  = row_at;
      run_len  = 11'd1;
    end else begin
      run_len = run_len + 11'd1;
    end

    if (last_row) begin
      if (cur_holes) begin
        if (run_open) add_span(run_top, run_len, 1'b0);
      end else begin
        add_span('0, eff_h, 1'b0);
      end
      add_span('0, '0, 1'b1);
      clear_tracking();
    end else begin
      row_at = row_at + 10'd1;
    end
  endfunction

  // Monitor: predict on accepted pixels and register writes, check accepted span words
  always @(posedge clk) begin
    if (!rst_n) begin
      px_fired   <= 1'b0;
      cfg_fired  <= 1'b0;
      cur_height = HeightResetVal;
      cur_wide   = WideResetVal;
      cur_holes  = HolesResetVal;
      clear_tracking();
    end else begin
      px_fired  <= px_ch.valid && px_ch.ready;
      cfg_fired <= cfg_ch.valid && cfg_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
      if (px_ch.valid && px_ch.ready) track_pixel(px_ch.pixel);
      if (span_ch.valid && span_ch.ready) begin
        if (spans_due.size() == 0) begin
          $error("span word with nothing expected: top_row=%0d run_length=%0d column_end=%0b",
                 span_ch.top_row, span_ch.run_length, span_ch.column_end);
          n_errors++;
        end else begin
          span_exp = spans_due.pop_front();
          if (span_ch.top_row !== span_exp.top_row) begin
            $error("top_row: expected %0d, got %0d", span_exp.top_row, span_ch.top_row);
            n_errors++;
          end
          if (span_ch.run_length !== span_exp.run_length) begin
            $error("run_length: expected %0d, got %0d",
                   span_exp.run_length, span_ch.run_length);
            n_errors++;
          end
          if (span_ch.column_end !== span_exp.column_end) begin
            $error("column_end: expected %0b, got %0b",
                   span_exp.column_end, span_ch.column_end);
            n_errors++;
          end
        end
      end
    end
  end

  // Pixel driver: present the next word once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      px_ch.valid <= 1'b0;
    end else if (!px_ch.valid || px_fired) begin
      if (pixels_todo.size() != 0 && !tx_hold && $urandom_range(99) >= tx_idle_pct) begin
        px_ch.valid <= 1'b1;
        px_ch.pixel <= pixels_todo.pop_front();
      end else begin
        px_ch.valid <= 1'b0;
      end
    end
  end

  // Span receiver: random stalls, plus a long hold-off counted down here
  always @(negedge clk) begin
    if (!rst_n) begin
      span_ch.ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      span_ch.ready <= 1'b0;
    end else begin
      span_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(negedge clk); while (!cfg_fired);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every pixel is taken and every expected span word has arrived
  task automatic wait_drained();
    do @(posedge clk); while (pixels_todo.size() != 0 || px_ch.valid);
    do @(negedge clk); while (spans_due.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic logic [PixelW-1:0] shaped_pixel(bit opaque, logic wide);
    logic [PixelW-1:0] p;
    p = $urandom;
    if (wide) p[31:24] = opaque ? 8'($urandom_range(1, 255)) : 8'h00;
    else      p[7:0]   = opaque ? 8'($urandom_range(1, 255)) : 8'h00;
    return p;
  endfunction

  // Queue pixels that form opaque runs in the current mode, with some raw noise
  task automatic queue_pixels(int n);
    bit opaque;
    opaque = 1'($urandom_range(1));
    @(posedge clk);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) opaque = !opaque;
      if ($urandom_range(99) < 8) pixels_todo.push_back($urandom);
      else pixels_todo.push_back(shaped_pixel(opaque, cur_wide));
    end
  endtask

  // Change some registers (possibly mid-column), then stream n pixels
  task automatic random_phase(int n);
    int              r;
    logic [CfgW-1:0] h;
    if ($urandom_range(99) < 60) begin
      r = $urandom_range(99);
      if (r < 5)       h = '0;
      else if (r < 12) h = 11'd1;
      else if (r < 85) h = 11'($urandom_range(2, 10));
      else             h = 11'($urandom_range(11, 40));
      write_reg(REG_COLUMN_HEIGHT, h);
    end
    if ($urandom_range(99) < 40)
      write_reg(REG_WIDE_PIXELS, {10'($urandom), 1'($urandom_range(1))});
    if ($urandom_range(99) < 40)
      write_reg(REG_HAS_HOLES, {10'($urandom), 1'($urandom_range(99) < 75)});
    if ($urandom_range(99) < 5) write_reg(RegUnused, 11'($urandom));
    queue_pixels(n);
    wait_drained();
  endtask

  initial begin
    int part_px;
    int n_px;
    rst_n         = 1'b0;
    px_ch.valid   = 1'b0;
    px_ch.pixel   = '0;
    span_ch.ready = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    tx_idle_pct   = 9;
    rx_idle_pct   = 74;
    rx_hold_left  = 0;
    tx_hold       = 1'b0;
    n_errors      = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Palette mode runs; upper bits of a palette pixel do not make it opaque
    write_reg(REG_COLUMN_HEIGHT, 11'd4);
    @(posedge clk);
    pixels_todo.push_back(32'h0000_00FF);
    pixels_todo.push_back(32'hFFFF_FF00);
    pixels_todo.push_back(32'h0000_0001);
    pixels_todo.push_back(32'hFFFF_FFFF);
    pixels_todo.push_back(32'hFFFF_FFFF);
    pixels_todo.push_back(32'hFFFF_FFFF);
    pixels_todo.push_back(32'h0000_0000);
    pixels_todo.push_back(32'h0000_0080);
    wait_drained();

    // Height zero acts as a single row
    write_reg(REG_COLUMN_HEIGHT, 11'd0);
    @(posedge clk);
    pixels_todo.push_back(32'h0000_0000);
    pixels_todo.push_back(32'hFFFF_FFFF);
    wait_drained();

    // Wide mode looks only at the alpha byte; unused index must be harmless
    write_reg(REG_WIDE_PIXELS, 11'd1);
    write_reg(REG_COLUMN_HEIGHT, 11'd3);
    write_reg(RegUnused, 11'h7FF);
    @(posedge clk);
    pixels_todo.push_back(32'h00FF_FFFF);
    pixels_todo.push_back(32'hFF00_0000);
    pixels_todo.push_back(32'h0100_0000);
    wait_drained();

    // Open a run, then lower the height and drop holes mid-column
    write_reg(REG_COLUMN_HEIGHT, 11'd6);
    @(posedge clk);
    pixels_todo.push_back(32'h8000_0000);
    pixels_todo.push_back(32'h8000_0000);
    pixels_todo.push_back(32'h8000_0000);
    wait_drained();
    write_reg(REG_WIDE_PIXELS, 11'd0);
    write_reg(REG_HAS_HOLES, 11'd0);
    write_reg(REG_COLUMN_HEIGHT, 11'd2);
    @(posedge clk);
    pixels_todo.push_back(32'h0000_0012);
    wait_drained();

    // No holes: one full span per column, runs tracked but not emitted
    write_reg(REG_COLUMN_HEIGHT, 11'd3);
    @(posedge clk);
    pixels_todo.push_back(32'h0000_0000);
    pixels_todo.push_back(32'h0000_0005);
    pixels_todo.push_back(32'h0000_0000);
    wait_drained();

    // Run state must start clean after a column end
    write_reg(REG_HAS_HOLES, 11'd1);
    write_reg(REG_COLUMN_HEIGHT, 11'd2);
    @(posedge clk);
    pixels_todo.push_back(32'hFFFF_FFFF);
    pixels_todo.push_back(32'hFFFF_FFFF);
    wait_drained();

    // Random phases under three idle regimes
    for (int part = 0; part < 3; part++) begin
      tx_idle_pct = (part == 0) ? 9 : (part == 1) ? 74 : 0;
      rx_idle_pct = (part == 0) ? 74 : (part == 1) ? 9 : 0;
      part_px = 0;
      while (part_px < PartPixels) begin
        n_px = $urandom_range(10, 80);
        random_phase(n_px);
        part_px += n_px;
      end

      if (part == 0) begin
        // Hold the sender mid-stream until every expected word is out
        write_reg(REG_COLUMN_HEIGHT, 11'd5);
        queue_pixels(120);
        do @(posedge clk); while (pixels_todo.size() > 60);
        tx_hold = 1'b1;
        do @(posedge clk); while (px_ch.valid);
        do @(negedge clk); while (spans_due.size() != 0);
        @(posedge clk);
        tx_hold = 1'b0;
        wait_drained();
      end

      if (part == 2) begin
        // Stall the receiver long enough for the block to back up its input
        write_reg(REG_HAS_HOLES, 11'd1);
        write_reg(REG_COLUMN_HEIGHT, 11'd3);
        queue_pixels(200);
        @(posedge clk);
        rx_hold_left = LongHold;
        wait_drained();

        // Tallest column: an over-range height clamps to the maximum
        write_reg(REG_HAS_HOLES, 11'($urandom_range(1)));
        write_reg(REG_COLUMN_HEIGHT, HeightOverMax);
        queue_pixels(1024 - int'(row_at));
        wait_drained();
      end
    end

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
